FILE: hdl/gnss_binary_frame_splitter_defines.svh
// assertion macros for the gnss binary frame splitter
// no dependencies; included by modules that carry assertions
`ifndef GNSS_BINARY_FRAME_SPLITTER_DEFINES_SVH
`define GNSS_BINARY_FRAME_SPLITTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define GBFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gbfs assertion failed");
`define GBFS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gbfs assertion failed");
`else
`define GBFS_ASSERT(lbl, clk, rst_n, prop)
`define GBFS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/gbfs_pkg.sv
// shared types and constants for the gnss binary frame splitter
// no dependencies
package gbfs_pkg;

    localparam int BUFFER_BYTES = 65536;
    localparam int POS_W        = $clog2(BUFFER_BYTES);

    localparam logic [7:0]  SYNC_FIRST  = 8'hBA;
    localparam logic [7:0]  SYNC_SECOND = 8'hCE;
    localparam logic [15:0] PAY_LIMIT_RESET = 16'd2048;
    localparam int          HEAD_BYTES  = 6;
    localparam int          TRAIL_BYTES = 4;

    localparam int K_W = 17;
    localparam logic [K_W-1:0] K_SYNC0  = K_W'(0);
    localparam logic [K_W-1:0] K_SYNC1  = K_W'(1);
    localparam logic [K_W-1:0] K_LEN_LO = K_W'(2);
    localparam logic [K_W-1:0] K_LEN_HI = K_W'(3);
    localparam logic [K_W-1:0] K_CLASS  = K_W'(4);
    localparam logic [K_W-1:0] K_MSG    = K_W'(5);

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_SYNC   = 2'd1,
        ST_LENGTH = 2'd2,
        ST_SUM    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_start;
    } t_in_item;

    typedef struct packed {
        t_status     frame_status;
        logic [15:0] frame_offset;
        logic [16:0] total_len;
        logic [15:0] pay_len;
        logic [7:0]  cls_byte;
        logic [7:0]  msg_byte;
    } t_result;

endpackage

FILE: hdl/gbfs_in_stage.sv
// input register stage of the frame splitter
// depends on gbfs_pkg
module gbfs_in_stage import gbfs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_take,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hdl/gbfs_parser.sv
// frame parse state, checksum and result register of the frame splitter
// depends on gbfs_pkg and gnss_binary_frame_splitter_defines.svh
`include "gnss_binary_frame_splitter_defines.svh"

module gbfs_parser import gbfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_pay_limit,
    input  logic        i_valid,
    output logic        o_take,
    input  t_in_item    i_item,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_fstart, n_fstart;
    logic [K_W-1:0]   r_k, n_k;
    logic             r_halted, n_halted;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_cls, n_cls;
    logic [7:0]       r_msg, n_msg;
    logic [31:0]      r_sum, n_sum;
    logic [23:0]      r_wa, n_wa;
    logic             r_mism, n_mism;
    logic             r_res_valid;
    t_result          r_res, n_res;

    logic             fire;
    logic             emit;
    logic [POS_W-1:0] pos;
    logic [K_W-1:0]   k;
    logic             halt;
    logic [7:0]       b;
    logic [1:0]       lane;
    logic             mism_now;

    assign fire   = i_valid && (!r_res_valid || i_res_ready);
    assign o_take = fire;
    assign b      = i_item.data_byte;
    assign lane   = 2'(r_k[1:0] - 2'd2 - r_len[1:0]);

    always_comb begin
        pos      = i_item.buffer_start ? '0 : r_pos;
        k        = i_item.buffer_start ? '0 : r_k;
        halt     = i_item.buffer_start ? 1'b0 : r_halted;
        n_pos    = r_pos;
        n_fstart = r_fstart;
        n_k      = r_k;
        n_halted = r_halted;
        n_len    = r_len;
        n_cls    = r_cls;
        n_msg    = r_msg;
        n_sum    = r_sum;
        n_wa     = r_wa;
        n_mism   = r_mism;
        emit     = 1'b0;
        mism_now = 1'b0;
        n_res    = '0;
        if (fire) begin
            n_pos    = (pos == POS_LAST) ? '0 : POS_W'(pos + 1'b1);
            n_k      = k;
            n_halted = halt;
            if (!halt) begin
                n_k = K_W'(k + 1'b1);
                case (k)
                    K_SYNC0: begin
                        n_fstart = pos;
                        if (b != SYNC_FIRST) begin
                            emit = 1'b1;
                            n_res.frame_status = ST_SYNC;
                        end
                    end
                    K_SYNC1: begin
                        if (b != SYNC_SECOND) begin
                            emit = 1'b1;
                            n_res.frame_status = ST_SYNC;
                        end
                    end
                    K_LEN_LO: n_len = {8'd0, b};
                    K_LEN_HI: begin
                        n_len = {b, r_len[7:0]};
                        if (n_len > i_pay_limit || n_len[1:0] != 2'd0) begin
                            emit = 1'b1;
                            n_res.frame_status = ST_LENGTH;
                            n_res.pay_len      = n_len;
                        end
                    end
                    K_CLASS: n_cls = b;
                    K_MSG: begin
                        n_msg  = b;
                        n_sum  = {b, r_cls, r_len};
                        n_wa   = '0;
                        n_mism = 1'b0;
                    end
                    default: begin
                        if (k < K_W'(r_len) + K_W'(HEAD_BYTES)) begin
                            case (lane)
                                2'd0: n_wa = {r_wa[23:8], b};
                                2'd1: n_wa = {r_wa[23:16], b, r_wa[7:0]};
                                2'd2: n_wa = {b, r_wa[15:0]};
                                default: begin
                                    n_sum = r_sum + {b, r_wa};
                                    n_wa  = '0;
                                end
                            endcase
                        end else begin
                            mism_now = r_sum[8*lane +: 8] != b;
                            n_mism   = r_mism || mism_now;
                            if (lane == 2'd3) begin
                                emit = 1'b1;
                                n_k  = '0;
                                n_halted = n_mism;
                                n_res.frame_status = n_mism ? ST_SUM : ST_GOOD;
                                n_res.total_len    = K_W'(r_len)
                                    + K_W'(HEAD_BYTES + TRAIL_BYTES);
                                n_res.pay_len      = r_len;
                                n_res.cls_byte     = r_cls;
                                n_res.msg_byte     = r_msg;
                            end
                        end
                    end
                endcase
                if (emit && n_res.frame_status != ST_GOOD) begin
                    n_halted = 1'b1;
                    n_k      = '0;
                end
            end
        end
        n_res.frame_offset = 16'(n_fstart);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_fstart    <= '0;
            r_k         <= '0;
            r_halted    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_fstart <= n_fstart;
            r_k      <= n_k;
            r_halted <= n_halted;
            if (fire && emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_cls  <= n_cls;
        r_msg  <= n_msg;
        r_sum  <= n_sum;
        r_wa   <= n_wa;
        r_mism <= n_mism;
        if (fire && emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `GBFS_ASSERT(a_good_len, i_clk, i_rst_n,
        (r_res_valid && r_res.frame_status == ST_GOOD)
            |-> (r_res.total_len == K_W'(r_res.pay_len) + K_W'(HEAD_BYTES + TRAIL_BYTES)))
    `GBFS_ASSERT(a_err_fields, i_clk, i_rst_n,
        (r_res_valid && (r_res.frame_status == ST_SYNC || r_res.frame_status == ST_LENGTH))
            |-> (r_res.total_len == '0 && r_res.cls_byte == '0 && r_res.msg_byte == '0))
    `GBFS_ASSERT(a_fault_halts, i_clk, i_rst_n,
        (fire && emit && n_res.frame_status != ST_GOOD) |=> r_halted)
    `GBFS_ASSERT(a_halt_idle, i_clk, i_rst_n,
        r_halted |-> (r_k == '0))

endmodule

FILE: hdl/gnss_binary_frame_splitter.sv
// gnss binary frame splitter, top level
// depends on gbfs_pkg, gbfs_in_stage and gbfs_parser
//
// Bytes of a receive buffer enter on the s_axis channel, one per transaction;
// tuser bit 0 marks the first byte of a new buffer, which clears the offset,
// any frame in progress and an error halt. Frames (sync BA CE, length,
// class, message id, payload, 32-bit sum trailer) are parsed back to back.
// Each good frame, and the first fault of a buffer, gives one transaction on
// the m_axis channel; after a fault bytes are ignored until the next buffer
// start. The cfg channel writes the largest accepted payload length (reset
// 2048) and is always ready; write it only while the block is idle.
// One byte is accepted per cycle while no m_axis stall holds a result. A
// byte passes an input register and is parsed into the result register.
// When m_axis stalls with a result pending, one more byte is held in the
// input register before s_axis tready drops. Reset clears both registers
// and the parse state; the block then behaves as if a buffer had started.
module gnss_binary_frame_splitter import gbfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,       // payload length limit
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic [0:0]  i_s_axis_tuser,   // buffer_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // frame_offset[15:0], total length[32:16], payload length[48:33],
    // class[56:49], message id[64:57], zero fill[71:65]
    output logic [71:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser    // frame_status
);

    logic [15:0] r_pay_limit;
    t_in_item    in_item;
    t_in_item    stage_item;
    logic        stage_valid;
    logic        take;
    t_result     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay_limit <= PAY_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_pay_limit <= i_cfg_data;
        end
    end

    assign in_item.data_byte    = i_s_axis_tdata;
    assign in_item.buffer_start = i_s_axis_tuser[0];

    gbfs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (take),
        .o_item  (stage_item)
    );

    gbfs_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pay_limit   (r_pay_limit),
        .i_valid       (stage_valid),
        .o_take        (take),
        .i_item        (stage_item),
        .o_res_valid   (o_m_axis_tvalid),
        .i_res_ready   (i_m_axis_tready),
        .o_res         (res)
    );

    assign o_m_axis_tdata = {7'd0, res.msg_byte, res.cls_byte, res.pay_len,
                             res.total_len, res.frame_offset};
    assign o_m_axis_tuser = res.frame_status;

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for gnss_binary_frame_splitter: byte streams of framed messages
// with sync, length and checksum faults, checked against an in-bench frame parser
// depends on gbfs_pkg and the gnss_binary_frame_splitter rtl
module tb_top;
    import gbfs_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef enum {FK_NONE, FK_SYNC_A, FK_SYNC_B, FK_LENGTH, FK_SUM} fault_kind_e;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    class frame_scoreboard;
        logic [15:0] pay_limit   = PAY_LIMIT_RESET;
        logic [15:0] position    = '0;
        logic [15:0] start_pos   = '0;
        logic [16:0] byte_idx    = '0;
        logic [15:0] length_hold = '0;
        logic [7:0]  class_hold  = '0;
        logic [7:0]  msg_hold    = '0;
        logic [31:0] word_sum    = '0;
        logic [23:0] word_part   = '0;
        bit          sum_bad     = 1'b0;
        bit          stopped     = 1'b0;
        t_result     expected_q[$];
        int          live_bytes  = 0;
        int          predicted   = 0;
        int          checked     = 0;
        int          errors      = 0;
        int          status_count[4] = '{0, 0, 0, 0};

        function void add_expect(t_status s, logic [16:0] flen, logic [15:0] plen,
                                 logic [7:0] cls, logic [7:0] msg);
            t_result r;
            r.frame_status = s;
            r.frame_offset = start_pos;
            r.total_len    = flen;
            r.pay_len      = plen;
            r.cls_byte     = cls;
            r.msg_byte     = msg;
            expected_q.insert(expected_q.size(), r);
            predicted++;
            status_count[int'(s)]++;
        endfunction

        function void fault(t_status s, logic [15:0] plen);
            stopped  = 1'b1;
            byte_idx = '0;
            add_expect(s, '0, plen, '0, '0);
        endfunction

        function void note_byte(logic [7:0] b, logic first_of_buffer);
            int k;
            int lane;
            logic [15:0] pos;
            if (first_of_buffer) begin
                position = '0;
                byte_idx = '0;
                stopped  = 1'b0;
            end
            pos      = position;
            position = position + 16'd1;
            if (stopped)
                return;
            live_bytes++;
            k = int'(byte_idx);
            if (k == 0) begin
                start_pos = pos;
                if (b != SYNC_FIRST) begin
                    fault(ST_SYNC, '0);
                    return;
                end
            end else if (k == 1) begin
                if (b != SYNC_SECOND) begin
                    fault(ST_SYNC, '0);
                    return;
                end
            end else if (k == 2) begin
                length_hold = {8'h00, b};
            end else if (k == 3) begin
                length_hold[15:8] = b;
                if (length_hold > pay_limit || length_hold[1:0] != 2'b00) begin
                    fault(ST_LENGTH, length_hold);
                    return;
                end
            end else if (k == 4) begin
                class_hold = b;
            end else if (k == 5) begin
                msg_hold  = b;
                word_sum  = {msg_hold, class_hold, length_hold};
                word_part = '0;
                sum_bad   = 1'b0;
            end else if (k < HEAD_BYTES + int'(length_hold)) begin
                lane = (k - HEAD_BYTES) % 4;
                if (lane < 3) begin
                    word_part = word_part | (24'(b) << (8 * lane));
                end else begin
                    word_sum  = word_sum + {b, word_part};
                    word_part = '0;
                end
            end else begin
                lane = (k - HEAD_BYTES - int'(length_hold)) % 4;
                if (word_sum[8 * lane +: 8] != b)
                    sum_bad = 1'b1;
                if (lane == 3) begin
                    add_expect(sum_bad ? ST_SUM : ST_GOOD,
                               17'(length_hold) + 17'(HEAD_BYTES + TRAIL_BYTES),
                               length_hold, class_hold, msg_hold);
                    if (sum_bad)
                        stopped = 1'b1;
                    byte_idx = '0;
                    return;
                end
            end
            byte_idx = 17'(k + 1);
        endfunction

        function void check(logic [1:0] st, logic [71:0] d);
            t_result want;
            t_result got;
            got.frame_status = t_status'(st);
            got.frame_offset = d[15:0];
            got.total_len    = d[32:16];
            got.pay_len      = d[48:33];
            got.cls_byte     = d[56:49];
            got.msg_byte     = d[64:57];
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d offset %0d", st, d[15:0]);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.frame_status !== want.frame_status
                    || got.frame_offset !== want.frame_offset
                    || got.total_len !== want.total_len
                    || got.pay_len !== want.pay_len
                    || got.cls_byte !== want.cls_byte || got.msg_byte !== want.msg_byte) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d mismatch", checked);
                    $display("  expected st %0d off %0d len %0d pay %0d cls %02h id %02h",
                             want.frame_status, want.frame_offset, want.total_len,
                             want.pay_len, want.cls_byte, want.msg_byte);
                    $display("  got      st %0d off %0d len %0d pay %0d cls %02h id %02h",
                             got.frame_status, got.frame_offset, got.total_len,
                             got.pay_len, got.cls_byte, got.msg_byte);
                end
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [15:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic [0:0]  i_s_axis_tuser  = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    frame_scoreboard sb = new;
    idle_mode_e      idle_mode = IDLE_NONE;
    logic [7:0]      frame_bytes[$];
    logic [15:0]     phase_max[8] = '{16'd64, 16'd0, 16'hFFFF, 16'd7,
                                      PAY_LIMIT_RESET, 16'd0, 16'd32, 16'd0};
    int              quiet_cycles = 0;

    gnss_binary_frame_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit idle_roll(bit receiver_side);
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 16;
        if ((idle_mode == IDLE_SENDER && !receiver_side)
                || (idle_mode == IDLE_RECEIVER && receiver_side))
            return $urandom_range(0, 99) < 49;
        return 1'b0;
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] v);
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= v)
            b = b + 8'd1;
        return b;
    endfunction

    function automatic void add_byte(logic [7:0] v);
        frame_bytes.insert(frame_bytes.size(), v);
    endfunction

    function automatic void build_frame(logic [15:0] plen, logic [7:0] cls, logic [7:0] msg,
                                        fault_kind_e fk);
        logic [31:0] sum;
        int idx;
        frame_bytes = '{SYNC_FIRST, SYNC_SECOND, plen[7:0], plen[15:8], cls, msg};
        if (fk == FK_SYNC_A)
            frame_bytes[0] = other_than(SYNC_FIRST);
        if (fk == FK_SYNC_B)
            frame_bytes[1] = other_than(SYNC_SECOND);
        if (fk == FK_SYNC_A || fk == FK_SYNC_B || fk == FK_LENGTH) begin
            // bytes after a fault are ignored until the next buffer start
            repeat ($urandom_range(0, 4))
                add_byte(8'($urandom));
            return;
        end
        sum = {msg, cls, plen};
        for (int i = 0; i < int'(plen); i++)
            add_byte(8'($urandom));
        for (int i = 0; i < int'(plen); i += 4)
            sum = sum + {frame_bytes[9 + i], frame_bytes[8 + i],
                         frame_bytes[7 + i], frame_bytes[6 + i]};
        if (fk == FK_SUM) begin
            idx = $urandom_range(0, 31);
            sum[idx] = ~sum[idx];
        end
        add_byte(sum[7:0]);
        add_byte(sum[15:8]);
        add_byte(sum[23:16]);
        add_byte(sum[31:24]);
    endfunction

    task automatic send_byte(logic [7:0] d, logic first);
        while (idle_roll(1'b0)) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_byte(d, first);
    endtask

    task automatic send_bytes(int count, bit with_start);
        for (int i = 0; i < count; i++)
            send_byte(frame_bytes[i], with_start && i == 0);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max(logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.pay_limit = v;
    endtask

    task automatic random_phase(logic [15:0] max_v, idle_mode_e mode);
        int live_base;
        int result_base;
        int roll;
        int lim;
        logic [15:0] plen;
        fault_kind_e fk;
        bit need_start;
        write_max(max_v);
        idle_mode   = mode;
        live_base   = sb.live_bytes;
        result_base = sb.predicted;
        need_start  = 1'b1;
        while (sb.live_bytes - live_base < 40 || sb.predicted - result_base < 3) begin
            roll = $urandom_range(0, 99);
            lim  = (max_v < 16'd16) ? int'(max_v) : 16;
            plen = 16'(4 * $urandom_range(0, lim / 4));
            fk   = FK_NONE;
            if (roll < 8) begin
                fk = roll[0] ? FK_SYNC_A : FK_SYNC_B;
            end else if (roll < 16) begin
                fk = FK_LENGTH;
                if (max_v < 16'd65532 && roll[0]) begin
                    plen = {max_v[15:2] + 14'd1, 2'b00};
                end else begin
                    plen = 16'($urandom);
                    if (plen[1:0] == 2'b00)
                        plen[0] = 1'b1;
                end
            end else if (roll < 24) begin
                fk = FK_SUM;
            end
            build_frame(plen, 8'($urandom), 8'($urandom), fk);
            if (roll >= 94) begin
                // frame cut short, then a new buffer
                send_bytes($urandom_range(1, frame_bytes.size() - 1), need_start);
                need_start = 1'b1;
            end else begin
                send_bytes(frame_bytes.size(), need_start || $urandom_range(0, 4) == 0);
                need_start = (fk != FK_NONE);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check(o_m_axis_tuser, o_m_axis_tdata);
        i_m_axis_tready <= !idle_roll(1'b1);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first frames arrive without a buffer start after reset
        idle_mode = IDLE_NONE;
        build_frame(16'd0, 8'hFF, 8'hFF, FK_NONE);
        send_bytes(frame_bytes.size(), 1'b0);
        build_frame(16'd4, 8'h00, 8'h00, FK_NONE);
        send_bytes(frame_bytes.size(), 1'b0);
        build_frame(16'd0, 8'($urandom), 8'($urandom), FK_SYNC_A);
        send_bytes(frame_bytes.size(), 1'b1);
        build_frame(16'd0, 8'($urandom), 8'($urandom), FK_SYNC_B);
        send_bytes(frame_bytes.size(), 1'b1);
        build_frame(16'd6, 8'($urandom), 8'($urandom), FK_LENGTH);
        send_bytes(frame_bytes.size(), 1'b1);
        build_frame(16'd2052, 8'($urandom), 8'($urandom), FK_LENGTH);
        send_bytes(frame_bytes.size(), 1'b1);
        build_frame(16'd4, 8'($urandom), 8'($urandom), FK_SUM);
        send_bytes(frame_bytes.size(), 1'b1);
        build_frame(16'd8, 8'($urandom), 8'($urandom), FK_NONE);
        send_bytes(frame_bytes.size(), 1'b1);
        build_frame(16'd12, 8'($urandom), 8'($urandom), FK_NONE);
        send_bytes(5, 1'b0);
        build_frame(16'd0, 8'($urandom), 8'($urandom), FK_NONE);
        send_bytes(frame_bytes.size(), 1'b1);

        for (int p = 0; p < 8; p++)
            random_phase((p == 5 || p == 7) ? 16'($urandom) : phase_max[p],
                         idle_mode_e'(p % 4));

        drain();
        repeat (6) @(posedge i_clk);

        $display("%0d bytes parsed, %0d frame results checked: %0d good, %0d bad sync,",
                 sb.live_bytes, sb.checked, sb.status_count[0], sb.status_count[1]);
        $display("%0d bad length, %0d checksum; %0d mismatches over eight payload limits",
                 sb.status_count[2], sb.status_count[3], sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
